// ----- rtl/vsts_pkg.sv -----
// Shared constants, codes and types of the valve time slot scheduler.
package vsts_pkg;

   // SLOT_DEPTH must be a power of two: slot numbers wrap by masking.
   localparam int SLOT_DEPTH      = 128;
   localparam int INTERVAL_CYCLES = 1000000;

   localparam int SLOT_W    = $clog2(SLOT_DEPTH);
   localparam int RUN_W     = $clog2(SLOT_DEPTH + 1);
   localparam int VALVE_W   = 16;
   localparam int CSR_ADDR_W = 5;

   localparam logic [31:0] INTERVAL_WORD = 32'(INTERVAL_CYCLES);

   // Reciprocal of the slot interval: q = (x * RECIP_MUL) >> RECIP_SHIFT is
   // exact for every 32-bit x.
   localparam int          RECIP_SHIFT = 32 + $clog2(INTERVAL_CYCLES);
   localparam logic [63:0] RECIP_ROUND = (64'd1 << RECIP_SHIFT) + 64'(INTERVAL_CYCLES)
                                         - 64'd1;
   localparam logic [32:0] RECIP_MUL   = 33'(RECIP_ROUND / 64'(INTERVAL_CYCLES));

   // Operation codes of the request word.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_ON_OFFSET     = 3'd0;
   localparam logic [2:0] REG_OFF_OFFSET    = 3'd1;
   localparam logic [2:0] REG_CALIBRATING   = 3'd2;
   localparam logic [2:0] REG_OVERRIDE_MASK = 3'd3;
   localparam logic [2:0] REG_START_TIME    = 3'd4;

   typedef struct packed {
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [VALVE_W-1:0] wr_data;
   } ring_cmd_type;

endpackage

// ----- rtl/vsts_req_if.sv -----
// Request channel: insert or tick words with valid/ready handshake.
interface vsts_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] begin_at;
   logic [31:0] end_at;
   logic [3:0]  first_index;
   logic [3:0]  last_index;

   modport source (
      output valid, operation, begin_at, end_at, first_index, last_index,
      input  ready
   );
   modport sink (
      input  valid, operation, begin_at, end_at, first_index, last_index,
      output ready
   );
endinterface

// ----- rtl/vsts_rsp_if.sv -----
// Response channel: valve words for ticks outside calibration, valid/ready handshake.
interface vsts_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] valve_word;

   modport source (
      output valid, valve_word,
      input  ready
   );
   modport sink (
      input  valid, valve_word,
      output ready
   );
endinterface

// ----- rtl/valve_time_slot_scheduler.sv -----
// Top level of the valve time slot scheduler: registers, sequencer, output stage.
//
//  channel  direction  handshake            word
//  req_ch   in         valid/ready          operation, begin_at, end_at, first/last_index
//  rsp_ch   out        valid/ready          valve_word (one per tick, none while calibrating)
//  csr_*    in/out     APB setup + access   on/off offsets, calibrating, override, start
//
// Insert: marks n slots (1..SLOT_DEPTH), or none when the run is empty.
//   Two passes of the shared reciprocal divider (begin slot, end slot), a
//   planning state, then one slot per cycle through the ring port.
// Tick: reads the slot, then waits while the output register is full.
// Reset (synchronous, active high) clears the ring through per-slot valid bits
//   at once, so no clearing pass is needed; registers and next due time go to 0.
// req_ch.ready is high only while the sequencer is idle; a held response does
//   not block inserts, only the completion of the next tick.
module valve_time_slot_scheduler import vsts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vsts_req_if.sink              req_ch,
   vsts_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] ST_CALC = 3'd1;
   localparam logic [STATE_W-1:0] ST_DIVB = 3'd2;
   localparam logic [STATE_W-1:0] ST_DIVE = 3'd3;
   localparam logic [STATE_W-1:0] ST_PLAN = 3'd5;
   localparam logic [STATE_W-1:0] ST_MARK = 3'd6;
   localparam logic [STATE_W-1:0] ST_TOUT = 3'd7;

   localparam logic signed [33:0] RUN_ONE   = 34'sd1;
   localparam logic signed [33:0] DEPTH_S34 = 34'(SLOT_DEPTH);

   // sequencer and configuration state
   logic [STATE_W-1:0] state_ff, state_in;
   logic [31:0]        on_off_ff, on_off_in;
   logic [31:0]        off_off_ff, off_off_in;
   logic               calib_ff, calib_in;
   logic [VALVE_W-1:0] ovr_ff, ovr_in;
   logic [31:0]        start_ff, start_in;
   logic [31:0]        next_due_ff, next_due_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [RUN_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic               rsp_vld_ff, rsp_vld_in;

   // item payload and working values
   logic [31:0]        begin_ff, begin_in;
   logic [31:0]        end_ff, end_in;
   logic [3:0]         first_ff, first_in;
   logic [3:0]         last_ff, last_in;
   logic [31:0]        re_ff, re_in;
   logic               re_lt_rb_ff, re_lt_rb_in;
   logic [VALVE_W-1:0] mask_ff, mask_in;
   logic [31:0]        qb_ff, qb_in;
   logic [31:0]        qe_ff, qe_in;
   logic [RUN_W-1:0]   n_ff, n_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0]  wa_ff, wa_in;
   logic [VALVE_W-1:0] rsp_word_ff, rsp_word_in;

   // combinational helpers
   logic               req_acc;
   logic               csr_wr;
   logic [2:0]         csr_idx;
   logic [31:0]        rb_c, re_c;
   logic [VALVE_W-1:0] mask_c;
   logic [31:0]        re_mag;
   logic signed [33:0] n_sig;
   logic               run_none;
   logic [RUN_W-1:0]   run_len;
   logic [SLOT_W:0]    start_sum;
   logic [SLOT_W-1:0]  start_idx;
   logic [SLOT_W-1:0]  ptr_next;
   logic [SLOT_W-1:0]  slot_next;
   logic               out_free;

   logic               div_start;
   logic [31:0]        div_dividend;
   logic [31:0]        div_quo;
   logic               div_done;

   ring_cmd_type       ring_cmd;
   logic [VALVE_W-1:0] ring_rd;

   vsts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .quotient  (div_quo),
      .done      (div_done)
   );

   vsts_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .rd_data (ring_rd)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_pready   = 1'b1;
   assign csr_wr       = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx      = csr_paddr[4:2];
   assign out_free     = !rsp_vld_ff || rsp_ch.ready;

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.valve_word = rsp_word_ff;

   // Offsets relative to the due time of the slot at the read position.
   always_comb begin
      rb_c = begin_ff - next_due_ff + on_off_ff;
      re_c = end_ff - next_due_ff + off_off_ff;
      for (int k = 0; k < VALVE_W; k++) begin
         mask_c[k] = (4'(k) >= first_ff) && (4'(k) <= last_ff);
      end
      re_mag = re_ff[31] ? (32'd0 - re_ff) : re_ff;
   end

   // Run length: an early end marks one slot; a negative end truncates toward zero.
   always_comb begin
      if (re_lt_rb_ff) begin
         n_sig = RUN_ONE;
      end else if (re_ff[31]) begin
         n_sig = RUN_ONE - $signed({2'b00, qe_ff});
      end else begin
         n_sig = $signed({2'b00, qe_ff}) + RUN_ONE - $signed({2'b00, qb_ff});
      end
      run_none = (n_sig <= 34'sd0) || (mask_ff == '0);
      run_len  = (n_sig > DEPTH_S34) ? RUN_W'(SLOT_DEPTH) : n_sig[RUN_W-1:0];
      // begin slot modulo the ring depth is its low bits
      start_sum = {1'b0, read_slot_ff} + {1'b0, qb_ff[SLOT_W-1:0]};
      if (start_sum >= (SLOT_W + 1)'(SLOT_DEPTH)) begin
         start_idx = SLOT_W'(start_sum - (SLOT_W + 1)'(SLOT_DEPTH));
      end else begin
         start_idx = start_sum[SLOT_W-1:0];
      end
      ptr_next  = (ptr_ff == SLOT_W'(SLOT_DEPTH - 1)) ? '0 : ptr_ff + SLOT_W'(1);
      slot_next = (read_slot_ff == SLOT_W'(SLOT_DEPTH - 1)) ? '0
                                                             : read_slot_ff + SLOT_W'(1);
   end

   // Divider operand select: begin slot, then end slot.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = rb_c[31] ? 32'd0 : rb_c;
      unique case (state_ff)
         ST_CALC: begin
            div_start = 1'b1;
         end
         ST_DIVB: begin
            div_start    = div_done;
            div_dividend = re_mag;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Ring port: tick read/clear, or read-modify-write one slot per cycle.
   always_comb begin
      ring_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.operation == OP_TICK) && !calib_ff) begin
               ring_cmd.rd_en   = 1'b1;
               ring_cmd.rd_addr = read_slot_ff;
            end
         end
         ST_MARK: begin
            if (cnt_ff < n_ff) begin
               ring_cmd.rd_en   = 1'b1;
               ring_cmd.rd_addr = ptr_ff;
            end
            if (pend_ff) begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_addr = wa_ff;
               ring_cmd.wr_data = ring_rd | mask_ff;
            end
         end
         ST_TOUT: begin
            if (out_free) begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_addr = read_slot_ff;
               ring_cmd.wr_data = '0;
            end
         end
         default: begin
            ring_cmd = '0;
         end
      endcase
   end

   // Sequencer and register file.
   always_comb begin
      state_in     = state_ff;
      on_off_in    = on_off_ff;
      off_off_in   = off_off_ff;
      calib_in     = calib_ff;
      ovr_in       = ovr_ff;
      start_in     = start_ff;
      next_due_in  = next_due_ff;
      read_slot_in = read_slot_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ch.ready;
      begin_in     = begin_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      re_in        = re_ff;
      re_lt_rb_in  = re_lt_rb_ff;
      mask_in      = mask_ff;
      qb_in        = qb_ff;
      qe_in        = qe_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      wa_in        = wa_ff;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.operation == OP_INSERT) begin
                  begin_in = req_ch.begin_at;
                  end_in   = req_ch.end_at;
                  first_in = req_ch.first_index;
                  last_in  = req_ch.last_index;
                  state_in = ST_CALC;
               end else if (!calib_ff) begin
                  state_in = ST_TOUT;
               end
            end
         end
         ST_CALC: begin
            re_in       = re_c;
            re_lt_rb_in = $signed(re_c) < $signed(rb_c);
            mask_in     = mask_c;
            state_in    = ST_DIVB;
         end
         ST_DIVB: begin
            if (div_done) begin
               qb_in    = div_quo;
               state_in = ST_DIVE;
            end
         end
         ST_DIVE: begin
            if (div_done) begin
               qe_in    = div_quo;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (run_none) begin
               state_in = ST_IDLE;
            end else begin
               n_in     = run_len;
               cnt_in   = '0;
               ptr_in   = start_idx;
               pend_in  = 1'b0;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (cnt_ff < n_ff) begin
               cnt_in  = cnt_ff + RUN_W'(1);
               ptr_in  = ptr_next;
               wa_in   = ptr_ff;
               pend_in = 1'b1;
            end else begin
               // last write drains this cycle
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_TOUT: begin
            if (out_free) begin
               rsp_word_in  = ring_rd | ovr_ff;
               rsp_vld_in   = 1'b1;
               read_slot_in = slot_next;
               next_due_in  = next_due_ff + INTERVAL_WORD;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         unique case (csr_idx)
            REG_ON_OFFSET:     on_off_in  = csr_pwdata;
            REG_OFF_OFFSET:    off_off_in = csr_pwdata;
            REG_CALIBRATING:   calib_in   = csr_pwdata[0];
            REG_OVERRIDE_MASK: ovr_in     = csr_pwdata[VALVE_W-1:0];
            REG_START_TIME: begin
               start_in    = csr_pwdata;
               next_due_in = csr_pwdata;
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ON_OFFSET:     csr_prdata = on_off_ff;
         REG_OFF_OFFSET:    csr_prdata = off_off_ff;
         REG_CALIBRATING:   csr_prdata = {31'd0, calib_ff};
         REG_OVERRIDE_MASK: csr_prdata = {16'd0, ovr_ff};
         REG_START_TIME:    csr_prdata = start_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         on_off_ff    <= '0;
         off_off_ff   <= '0;
         calib_ff     <= 1'b0;
         ovr_ff       <= '0;
         start_ff     <= '0;
         next_due_ff  <= '0;
         read_slot_ff <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         on_off_ff    <= on_off_in;
         off_off_ff   <= off_off_in;
         calib_ff     <= calib_in;
         ovr_ff       <= ovr_in;
         start_ff     <= start_in;
         next_due_ff  <= next_due_in;
         read_slot_ff <= read_slot_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      begin_ff    <= begin_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      re_ff       <= re_in;
      re_lt_rb_ff <= re_lt_rb_in;
      mask_ff     <= mask_in;
      qb_ff       <= qb_in;
      qe_ff       <= qe_in;
      n_ff        <= n_in;
      ptr_ff      <= ptr_in;
      wa_ff       <= wa_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef NO_ASSERTIONS
   // a response word only appears after a tick completes
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_TOUT))
      else $error("response raised outside tick completion");

   // the marking pass never runs past its run length
   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (cnt_ff <= n_ff) && (n_ff <= RUN_W'(SLOT_DEPTH)))
      else $error("slot marking overran its run");

   // divider results are consumed only by the divide wait states
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVB) || (state_ff == ST_DIVE))
      else $error("divider finished outside a divide state");

   // read position stays inside the ring
   a_read_slot_range: assert property (@(posedge clock) disable iff (reset)
      read_slot_ff <= SLOT_W'(SLOT_DEPTH - 1))
      else $error("read slot out of ring range");
`endif

endmodule

// ----- rtl/vsts_div.sv -----
// Shared slot divider: reciprocal multiply by the slot interval, result in the cycle after start.
module vsts_div import vsts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [31:0]  dividend,
   output logic [31:0]  quotient,
   output logic         done
);

   logic [64:0]          prod_ff, prod_in;
   logic                 done_ff, done_in;

   always_comb begin
      prod_in = prod_ff;
      done_in = start;
      if (start) begin
         prod_in = {32'd0, RECIP_MUL} * {33'd0, dividend};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign quotient = 32'(prod_ff >> RECIP_SHIFT);
   assign done     = done_ff;

endmodule

// ----- rtl/vsts_ring.sv -----
// Slot ring: valve mask memory with per-slot valid bits, registered read.
module vsts_ring import vsts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ring_cmd_type       cmd,
   output logic [VALVE_W-1:0] rd_data
);

   logic [VALVE_W-1:0]    mem_ff [SLOT_DEPTH];
   logic [VALVE_W-1:0]    rd_ff;
   logic [SLOT_DEPTH-1:0] vld_ff, vld_in;
   logic                  hit_ff, hit_in;

   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.wr_addr] = 1'b1;
      end
      hit_in = hit_ff;
      if (cmd.rd_en) begin
         hit_in = vld_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         hit_ff <= hit_in;
      end
   end

   // a slot never written since reset reads as empty
   assign rd_data = hit_ff ? rd_ff : '0;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the valve time slot scheduler: predicts and checks every valve word.
module tb_top;
   import vsts_pkg::*;

   // One request word as the sender builds it.
   typedef struct packed {
      logic        operation;
      logic [31:0] begin_at;
      logic [31:0] end_at;
      logic [3:0]  first_index;
      logic [3:0]  last_index;
   } slot_request_type;

   localparam int     HOLD_CYCLES   = 3000;  // long receiver hold-off
   localparam int     SETTLE_CYCLES = 300;   // room for the longest insert to finish
   localparam longint SLOT_CYCLES   = INTERVAL_CYCLES;

   // Shadow copy of the ring, the read position, the due time and the
   // registers; turns each accepted word into the valve words it must cause.
   class valve_slot_model;
      logic [VALVE_W-1:0] ring [SLOT_DEPTH];
      logic [SLOT_W-1:0]  read_pos;
      logic [31:0]        due;
      logic [31:0]        on_offset;
      logic [31:0]        off_offset;
      logic               calibrating;
      logic [VALVE_W-1:0] override_mask;
      logic [VALVE_W-1:0] pending_words [$];
      int                 errors;

      function new();
         foreach (ring[i]) ring[i] = '0;
         read_pos      = '0;
         due           = '0;
         on_offset     = '0;
         off_offset    = '0;
         calibrating   = 1'b0;
         override_mask = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_ON_OFFSET:     on_offset = value;
            REG_OFF_OFFSET:    off_offset = value;
            REG_CALIBRATING:   calibrating = value[0];
            REG_OVERRIDE_MASK: override_mask = value[VALVE_W-1:0];
            REG_START_TIME:    due = value;
            default: ;
         endcase
      endfunction

      // Set the valve range in every slot the insert covers.
      function void mark_slots(slot_request_type r);
         logic [31:0]        rb_word;
         logic [31:0]        re_word;
         longint             rb;
         longint             re;
         longint             first_slot;
         longint             stop_slot;
         longint             run;
         longint             i;
         logic [VALVE_W-1:0] mask;
         int                 k;
         int                 idx;
         rb_word = r.begin_at - due + on_offset;
         re_word = r.end_at - due + off_offset;
         rb = longint'($signed(rb_word));
         re = longint'($signed(re_word));
         first_slot = (rb < 0) ? 0 : rb / SLOT_CYCLES;
         // division truncates toward zero, which is what a negative end needs
         stop_slot = (re < rb) ? first_slot + 1 : re / SLOT_CYCLES + 1;
         mask = '0;
         for (k = 0; k < VALVE_W; k++) begin
            if (k >= r.first_index && k <= r.last_index) mask[k] = 1'b1;
         end
         if (stop_slot <= first_slot || mask == '0) return;
         run = stop_slot - first_slot;
         if (run > SLOT_DEPTH) run = SLOT_DEPTH;
         for (i = 0; i < run; i++) begin
            idx = int'((longint'(read_pos) + first_slot + i) % SLOT_DEPTH);
            ring[idx] = ring[idx] | mask;
         end
      endfunction

      function void note_word(slot_request_type r);
         if (r.operation == OP_INSERT) begin
            mark_slots(r);
         end else if (!calibrating) begin
            pending_words.push_back(ring[read_pos] | override_mask);
            ring[read_pos] = '0;
            read_pos = SLOT_W'((read_pos + 1) % SLOT_DEPTH);
            due = due + 32'(INTERVAL_CYCLES);
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t ns  valve word mismatch: %s", $time, what);
         errors++;
      endtask

      task check_valve(logic [VALVE_W-1:0] got);
         logic [VALVE_W-1:0] want;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("got %h with nothing expected", got));
         end else begin
            want = pending_words.pop_front();
            if (got !== want)
               report_mismatch($sformatf("got %h, expected %h", got, want));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   vsts_req_if req_ch ();
   vsts_rsp_if rsp_ch ();

   valve_slot_model slots;

   // Handshake between the sender and the receiver process.
   bit hold_request;   // ask the receiver for one long hold-off
   bit tail_quiet;     // no idling on either side
   int hold_left;
   int run_left;
   int stall_left;

   valve_time_slot_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // APB write: setup cycle, then access cycle until pready.
   task csr_write(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      slots.write_reg(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one word and hold it until the block takes it. Valid stays high
   // afterwards so that a following word goes out back to back.
   task send_request(slot_request_type r);
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= r.operation;
      req_ch.begin_at    <= r.begin_at;
      req_ch.end_at      <= r.end_at;
      req_ch.first_index <= r.first_index;
      req_ch.last_index  <= r.last_index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      slots.note_word(r);
   endtask

   // Drop valid for a random burst now and then.
   task sender_gap();
      if (!tail_quiet && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 15)) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
   endtask

   // Stop offering and wait until every expected word has come back.
   task wait_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (slots.pending_words.size() != 0) @(posedge clock);
   endtask

   // Drain, then let a trailing insert finish before touching registers.
   task settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic slot_request_type insert_req(logic [31:0] b, logic [31:0] e,
                                                   logic [3:0] f, logic [3:0] l);
      slot_request_type r;
      r.operation   = OP_INSERT;
      r.begin_at    = b;
      r.end_at      = e;
      r.first_index = f;
      r.last_index  = l;
      return r;
   endfunction

   // Tick with junk in the fields it ignores.
   function automatic slot_request_type tick_req();
      slot_request_type r;
      r.operation   = OP_TICK;
      r.begin_at    = $urandom;
      r.end_at      = $urandom;
      r.first_index = 4'($urandom);
      r.last_index  = 4'($urandom);
      return r;
   endfunction

   function automatic int small_offset();
      return int'($urandom_range(0, 4000000)) - 2000000;
   endfunction

   // Mostly ticks and well-formed inserts aimed at slots ahead of the read
   // position (offsets cancelled out), plus too-early ends, begins in the
   // past and fully random inserts.
   function automatic slot_request_type random_request();
      slot_request_type r;
      int            pick;
      int            lead;
      int            span;
      logic [31:0]   base_b;
      logic [31:0]   base_e;
      logic [3:0]    swap;
      pick = $urandom_range(0, 99);
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 12);
      span = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 260) : $urandom_range(0, 6);
      base_b = slots.due - slots.on_offset;
      base_e = slots.due - slots.off_offset;
      r = tick_req();
      r.operation = OP_INSERT;
      // keep most valve ranges in order, leave some reversed
      if (r.first_index > r.last_index && $urandom_range(0, 9) != 0) begin
         swap          = r.first_index;
         r.first_index = r.last_index;
         r.last_index  = swap;
      end
      if (pick < 40) begin
         r.operation = OP_TICK;
      end else if (pick < 75) begin
         r.begin_at = base_b + lead * INTERVAL_CYCLES + $urandom_range(0, INTERVAL_CYCLES - 1);
         r.end_at   = base_e + (lead + span) * INTERVAL_CYCLES
                      + $urandom_range(0, INTERVAL_CYCLES - 1);
      end else if (pick < 85) begin
         r.begin_at = base_b + lead * INTERVAL_CYCLES + $urandom_range(0, INTERVAL_CYCLES - 1);
         r.end_at   = base_e + lead * INTERVAL_CYCLES - $urandom_range(1, 3 * INTERVAL_CYCLES);
      end else if (pick < 90) begin
         r.begin_at = base_b - $urandom_range(1, 5 * INTERVAL_CYCLES);
         r.end_at   = base_e + $urandom_range(0, 6 * INTERVAL_CYCLES);
      end
      return r;
   endfunction

   // Write every register for one phase of the run.
   task apply_phase(int phase);
      logic [31:0]        on_v;
      logic [31:0]        off_v;
      logic               cal_v;
      logic [VALVE_W-1:0] ovr_v;
      logic [31:0]        start_v;
      on_v    = small_offset();
      off_v   = small_offset();
      cal_v   = 1'b0;
      ovr_v   = VALVE_W'($urandom);
      start_v = $urandom;
      case (phase)
         1: begin
            on_v    = 32'h8000_0000;
            off_v   = 32'h7FFF_FFFF;
            ovr_v   = 16'hFFFF;
            start_v = 32'hFFFF_FFFF;
         end
         2: begin
            on_v    = 32'h7FFF_FFFF;
            off_v   = 32'h8000_0000;
            ovr_v   = 16'h0000;
            start_v = 32'h0000_0000;
         end
         3: cal_v = 1'b1;
         4: begin
            on_v  = -20;
            off_v = 100;
            ovr_v = 16'h0001;
         end
         default: ;
      endcase
      csr_write(REG_ON_OFFSET, on_v);
      csr_write(REG_OFF_OFFSET, off_v);
      csr_write(REG_CALIBRATING, {31'd0, cal_v});
      csr_write(REG_OVERRIDE_MASK, {16'd0, ovr_v});
      csr_write(REG_START_TIME, start_v);
   endtask

   // Receiver: random ready bursts, one long hold-off on request, and
   // steady ready in the tail.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (tail_quiet) begin
            rsp_ch.ready <= 1'b1;
         end else if (run_left > 0) begin
            rsp_ch.ready <= 1'b1;
            run_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            run_left   = $urandom_range(0, 39);
            stall_left = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Check each valve word as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         slots.check_valve(rsp_ch.valve_word);
   end

   // Hard stop in case the block hangs.
   initial begin
      #20000000;
      $display("tb_top failed");
      $finish;
   end

   // Main sequence: reset, directed words, then six register phases of
   // random traffic.
   initial begin
      int count;
      int phase;
      int n;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_INSERT;
      req_ch.begin_at    = '0;
      req_ch.end_at      = '0;
      req_ch.first_index = '0;
      req_ch.last_index  = '0;
      tail_quiet         = 1'b0;
      slots = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, registers at their reset values.
      send_request(insert_req(32'd0, 32'd0, 4'd0, 4'd15));               // full range, slot 0
      send_request(insert_req(3 * INTERVAL_CYCLES, 5 * INTERVAL_CYCLES - 1, 4'd15, 4'd15));
      send_request(insert_req(INTERVAL_CYCLES, 2 * INTERVAL_CYCLES, 4'd15, 4'd0)); // reversed
      send_request(insert_req(2 * INTERVAL_CYCLES, INTERVAL_CYCLES, 4'd4, 4'd7));  // early end
      send_request(insert_req(32'hFFFF_FFFF, INTERVAL_CYCLES, 4'd0, 4'd0));  // begin in past
      send_request(insert_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd1, 4'd2));   // farthest slot
      send_request(insert_req(32'h8000_0000, 32'h8000_0001, 4'd3, 4'd3));   // ends too soon
      send_request(insert_req(32'h8000_0000, 32'hFFFF_FFFF, 4'd5, 4'd6));   // end just negative
      send_request(insert_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd10, 4'd12));
      send_request(insert_req(10 * INTERVAL_CYCLES, 10 * INTERVAL_CYCLES, 4'd0, 4'd15));
      send_request(insert_req(32'd0, 200 * INTERVAL_CYCLES, 4'd8, 4'd9));   // wraps whole ring
      send_request(insert_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 4'd15));
      repeat (12) begin
         send_request(tick_req());
         sender_gap();
      end

      for (phase = 0; phase < 6; phase++) begin
         settle();
         apply_phase(phase);
         tail_quiet = (phase == 5);
         count = (phase == 3) ? 60 : 125;
         for (n = 0; n < count; n++) begin
            // fill the block behind a stalled receiver
            if (phase == 0 && n == 10) hold_request = 1'b1;
            // pause until everything is back
            if (phase == 2 && n == 60) wait_results();
            send_request(random_request());
            sender_gap();
         end
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (slots.errors == 0 && slots.pending_words.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/vsts_pkg.sv
rtl/vsts_req_if.sv
rtl/vsts_rsp_if.sv
rtl/vsts_div.sv
rtl/vsts_ring.sv
rtl/valve_time_slot_scheduler.sv
bench/tb_top.sv
